// ===== rtl/tcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcs_pkg;

    localparam int DefMaxWidth = 1024;
    localparam int DefMaxTrees = 220;
    localparam int MaxDepth    = 1024;
    localparam int RowW        = 11;
    localparam int CoordW      = 10;
    localparam int ScoreW      = 24;
    localparam int HeightW     = 16;
    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = 32;

    localparam logic [1:0] CmdSample = 2'd0;
    localparam logic [1:0] CmdFetch  = 2'd1;
    localparam logic [1:0] CmdNewMap = 2'd2;

    localparam logic [CfgIdxW-1:0] CfgMapWidth    = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgMapDepth    = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgHashSeed    = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgGroundFloor = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgSlopeLimit  = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgPlacementOn = 3'd5;

    localparam logic [10:0] RstMapWidth    = 11'd64;
    localparam logic [10:0] RstMapDepth    = 11'd64;
    localparam logic [31:0] RstHashSeed    = 32'd0;
    localparam logic [15:0] RstGroundFloor = 16'd46;
    localparam logic [15:0] RstSlopeLimit  = 16'd294;

    localparam logic [ScoreW-1:0] ScoreLimit = 24'd7046430;

    localparam logic [31:0] HashMulX   = 32'h9e3779b1;
    localparam logic [31:0] HashMulZ   = 32'h85ebca77;
    localparam logic [31:0] HashMix1   = 32'h7feb352d;
    localparam logic [31:0] HashMix2   = 32'h846ca68b;
    localparam logic [63:0] HashSaltW  = 64'd10 * 64'hc2b2ae3d;
    localparam logic [31:0] HashSalt   = HashSaltW[31:0];

    localparam int MinTrees  = 8;
    localparam int DivShift  = 26;
    localparam int RecipW    = 21;
    localparam logic [RecipW-1:0] DivRecip = RecipW'(((1 << DivShift) + 54) / 55);

    typedef struct packed {
        logic [ScoreW-1:0] score;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] z;
    } cell_entry_t;

endpackage

`default_nettype wire

// ===== rtl/tcs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcs_cell
    import tcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        ins_en,
    input  wire cell_entry_t ins,
    input  wire cell_entry_t prev,
    input  wire logic        prev_gt,
    input  wire logic        occupied,
    input  wire logic        at_end,
    output cell_entry_t      entry,
    output logic             gt
);

    cell_entry_t entry_reg;

    assign gt    = occupied && (entry_reg.score > ins.score);
    assign entry = entry_reg;

    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            if (prev_gt)
            begin
                entry_reg <= prev;
            end
            else if (gt || at_end)
            begin
                entry_reg <= ins;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tcs_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcs_chain
    import tcs_pkg::*;
#(
    parameter int MAX_TREES = DefMaxTrees,
    parameter int KW = $clog2(MAX_TREES + 1),
    parameter int IW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1
)
(
    input  wire logic          clk,
    input  wire logic          ins_en,
    input  wire cell_entry_t   ins,
    input  wire logic [KW-1:0] kept,
    input  wire logic [IW-1:0] rd_idx,
    output cell_entry_t        rd_entry
);

    cell_entry_t ent [MAX_TREES];
    logic        gts [MAX_TREES];
    cell_entry_t rd_entry_reg;

    for (genvar i = 0; i < MAX_TREES; i++)
    begin : g_cell
        cell_entry_t prev_w;
        logic        prev_gt_w;

        if (i == 0)
        begin : g_head
            assign prev_w    = ins;
            assign prev_gt_w = 1'b0;
        end
        else
        begin : g_body
            assign prev_w    = ent[i-1];
            assign prev_gt_w = gts[i-1];
        end

        tcs_cell u_cell (
            .clk      (clk),
            .ins_en   (ins_en),
            .ins      (ins),
            .prev     (prev_w),
            .prev_gt  (prev_gt_w),
            .occupied (KW'(i) < kept),
            .at_end   (kept == KW'(i)),
            .entry    (ent[i]),
            .gt       (gts[i])
        );
    end

    always_ff @(posedge clk)
    begin
        rd_entry_reg <= ent[rd_idx];
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

// ===== rtl/tcs_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcs_hash
    import tcs_pkg::*;
#(
    parameter int XW = 10
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [31:0]       seed,
    input  wire logic [XW-1:0]     cx,
    input  wire logic [CoordW-1:0] cz,
    output logic                   done,
    output logic [ScoreW-1:0]      score
);

    logic [3:0]        vld_reg;
    logic [31:0]       h_reg;
    logic [31:0]       m1_reg;
    logic [31:0]       m2_reg;
    logic [ScoreW-1:0] score_reg;
    logic [31:0]       xm;
    logic [31:0]       zm;
    logic [31:0]       v1;
    logic [31:0]       v2;
    logic [31:0]       v3;

    assign xm = 32'(cx) * HashMulX;
    assign zm = 32'(cz) * HashMulZ;
    assign v1 = h_reg ^ (h_reg >> 16);
    assign v2 = m1_reg ^ (m1_reg >> 15);
    assign v3 = m2_reg ^ (m2_reg >> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg     <= seed ^ xm ^ zm ^ HashSalt;
        m1_reg    <= v1 * HashMix1;
        m2_reg    <= v2 * HashMix2;
        score_reg <= v3[ScoreW-1:0];
    end

    assign done  = vld_reg[3];
    assign score = score_reg;

endmodule

`default_nettype wire

// ===== rtl/terrain_cell_topk_selector.sv =====
// A height sample passes through the line state; a qualifying sample then waits in
// the hash state for the 4-stage hash pipeline. A fetch steps through the product,
// quotient and fetch states; its word is loaded into the output register once the
// output is free. Cell insertion into the sorted chain of cells is a single shift.
// Input stalls while an item is in flight; a fetch waits longer while output stalls.
// Reset clears counters and window registers and loads the default configuration;
// line buffers and chain contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module terrain_cell_topk_selector
    import tcs_pkg::*;
#(
    parameter int MAX_WIDTH = DefMaxWidth,
    parameter int MAX_TREES = DefMaxTrees
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          cmd,
    input  wire logic [15:0]         height,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     found,
    output logic [CoordW-1:0]        cell_x,
    output logic [CoordW-1:0]        cell_z,
    output logic                     last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int W1 = $clog2(MAX_WIDTH + 1);
    localparam int KW = $clog2(MAX_TREES + 1);
    localparam int IW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int PW = $clog2(MAX_WIDTH * MaxDepth + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LINE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_PROD  = 3'd3;
    localparam logic [2:0] ST_QUOT  = 3'd4;
    localparam logic [2:0] ST_FETCH = 3'd5;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;

    logic [10:0]         map_width_reg;
    logic [10:0]         map_depth_reg;
    logic [31:0]         hash_seed_reg;
    logic [15:0]         ground_floor_reg;
    logic [15:0]         slope_limit_reg;
    logic                placement_on_reg;

    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    logic [RowW-1:0]     row_reg;
    logic [RowW-1:0]     row_next;
    logic [KW-1:0]       kept_reg;
    logic [KW-1:0]       kept_next;
    logic [KW-1:0]       fetch_reg;
    logic [KW-1:0]       fetch_next;

    logic [15:0]         win_c2_reg;
    logic [15:0]         win_c1_reg;
    logic [15:0]         win_a1_reg;
    logic [15:0]         win_b1_reg;

    logic [CW-1:0]       x_reg;
    logic [RowW-1:0]     z_reg;
    logic [15:0]         hv_reg;
    logic [15:0]         old_c_reg;
    logic [15:0]         old_a_reg;

    logic [15:0]         row_above_mem  [MAX_WIDTH];
    logic [15:0]         row_center_mem [MAX_WIDTH];

    logic [PW-1:0]       prod_reg;
    logic [PW-1:0]       quot_reg;

    logic                out_valid_reg;
    logic                found_reg;
    logic [CoordW-1:0]   cell_x_reg;
    logic [CoordW-1:0]   cell_z_reg;
    logic                last_reg;

    logic [W1-1:0]       w_eff;
    logic [RowW-1:0]     d_eff;
    logic                accept;
    logic                wrap;
    logic [CW-1:0]       x_cur;
    logic [RowW-1:0]     z_cur;
    logic [W1-1:0]       x_inc;
    logic                qualify;
    logic [CW-1:0]       cx;
    logic                hash_done;
    logic [ScoreW-1:0]   hash_score;
    logic                ins_en;
    cell_entry_t         ins;
    cell_entry_t         rd_entry;
    logic [PW+RecipW-1:0] quot_wide;
    logic [KW-1:0]       want;
    logic [KW-1:0]       limit;
    logic                out_free;

    function automatic logic slope_ok(logic [15:0] n, logic [15:0] c, logic [15:0] lim);
        logic [16:0] d;
        logic [16:0] ad;
        d  = {n[15], n} - {c[15], c};
        ad = d[16] ? (17'd0 - d) : d;
        return ad <= {1'b0, lim};
    endfunction

    always_comb
    begin
        if (map_width_reg < 11'd3)
        begin
            w_eff = W1'(3);
        end
        else if ({2'b00, map_width_reg} > 13'(MAX_WIDTH))
        begin
            w_eff = W1'(MAX_WIDTH);
        end
        else
        begin
            w_eff = W1'(map_width_reg);
        end
        if (map_depth_reg < 11'd3)
        begin
            d_eff = RowW'(3);
        end
        else if (map_depth_reg > 11'(MaxDepth))
        begin
            d_eff = RowW'(MaxDepth);
        end
        else
        begin
            d_eff = map_depth_reg;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign wrap     = (W1'(col_reg) >= w_eff);
    assign x_cur    = wrap ? '0 : col_reg;
    assign z_cur    = wrap ? (row_reg + RowW'(1)) : row_reg;
    assign x_inc    = W1'(x_cur) + W1'(1);
    assign cx       = x_reg - CW'(1);

    assign qualify = (x_reg >= CW'(2)) && (z_reg >= RowW'(2)) && placement_on_reg
                     && ($signed(win_c1_reg) > $signed(ground_floor_reg))
                     && slope_ok(old_c_reg, win_c1_reg, slope_limit_reg)
                     && slope_ok(win_c2_reg, win_c1_reg, slope_limit_reg)
                     && slope_ok(win_a1_reg, win_c1_reg, slope_limit_reg)
                     && slope_ok(win_b1_reg, win_c1_reg, slope_limit_reg);

    tcs_hash #(
        .XW (CW)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start ((state_reg == ST_LINE) && qualify),
        .seed  (hash_seed_reg),
        .cx    (cx),
        .cz    (CoordW'(z_reg - RowW'(1))),
        .done  (hash_done),
        .score (hash_score)
    );

    assign ins_en    = (state_reg == ST_HASH) && hash_done && (hash_score <= ScoreLimit);
    assign ins.score = hash_score;
    assign ins.x     = CoordW'(cx);
    assign ins.z     = CoordW'(z_reg - RowW'(1));

    tcs_chain #(
        .MAX_TREES (MAX_TREES),
        .KW        (KW),
        .IW        (IW)
    ) u_chain (
        .clk      (clk),
        .ins_en   (ins_en),
        .ins      (ins),
        .kept     (kept_reg),
        .rd_idx   (fetch_reg[IW-1:0]),
        .rd_entry (rd_entry)
    );

    assign quot_wide = (PW+RecipW)'(prod_reg) * (PW+RecipW)'(DivRecip);

    always_comb
    begin
        if (quot_reg < PW'(MinTrees))
        begin
            want = KW'(MinTrees);
        end
        else if (quot_reg > PW'(MAX_TREES))
        begin
            want = KW'(MAX_TREES);
        end
        else
        begin
            want = KW'(quot_reg);
        end
        limit = (kept_reg < want) ? kept_reg : want;
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        kept_next  = kept_reg;
        fetch_next = fetch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CmdSample:
                        begin
                            if (z_cur < d_eff)
                            begin
                                state_next = ST_LINE;
                                if (x_inc >= w_eff)
                                begin
                                    col_next = '0;
                                    row_next = z_cur + RowW'(1);
                                end
                                else
                                begin
                                    col_next = CW'(x_inc);
                                    row_next = z_cur;
                                end
                            end
                            else
                            begin
                                col_next = x_cur;
                                row_next = z_cur;
                            end
                        end
                        CmdFetch:
                        begin
                            state_next = ST_PROD;
                        end
                        CmdNewMap:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            kept_next  = '0;
                            fetch_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LINE:
            begin
                state_next = qualify ? ST_HASH : ST_IDLE;
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    state_next = ST_IDLE;
                    if (ins_en && (kept_reg < KW'(MAX_TREES)))
                    begin
                        kept_next = kept_reg + KW'(1);
                    end
                end
            end
            ST_PROD:
            begin
                state_next = ST_QUOT;
            end
            ST_QUOT:
            begin
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    if (fetch_reg < limit)
                    begin
                        fetch_next = fetch_reg + KW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            col_reg          <= '0;
            row_reg          <= '0;
            kept_reg         <= '0;
            fetch_reg        <= '0;
            win_c2_reg       <= '0;
            win_c1_reg       <= '0;
            win_a1_reg       <= '0;
            win_b1_reg       <= '0;
            map_width_reg    <= RstMapWidth;
            map_depth_reg    <= RstMapDepth;
            hash_seed_reg    <= RstHashSeed;
            ground_floor_reg <= RstGroundFloor;
            slope_limit_reg  <= RstSlopeLimit;
            placement_on_reg <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            kept_reg  <= kept_next;
            fetch_reg <= fetch_next;
            if (state_reg == ST_LINE)
            begin
                win_c2_reg <= win_c1_reg;
                win_c1_reg <= old_c_reg;
                win_a1_reg <= old_a_reg;
                win_b1_reg <= hv_reg;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CfgMapWidth:    map_width_reg    <= cfg_data[10:0];
                    CfgMapDepth:    map_depth_reg    <= cfg_data[10:0];
                    CfgHashSeed:    hash_seed_reg    <= cfg_data;
                    CfgGroundFloor: ground_floor_reg <= cfg_data[15:0];
                    CfgSlopeLimit:  slope_limit_reg  <= cfg_data[15:0];
                    CfgPlacementOn: placement_on_reg <= cfg_data[0];
                    default:        placement_on_reg <= placement_on_reg;
                endcase
            end
            if ((state_reg == ST_FETCH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (cmd == CmdSample))
        begin
            x_reg     <= x_cur;
            z_reg     <= z_cur;
            hv_reg    <= height;
            old_c_reg <= row_center_mem[x_cur];
            old_a_reg <= row_above_mem[x_cur];
        end
        if (state_reg == ST_LINE)
        begin
            row_center_mem[x_reg] <= hv_reg;
            row_above_mem[x_reg]  <= old_c_reg;
        end
        prod_reg <= PW'(w_eff) * PW'(d_eff);
        quot_reg <= PW'(quot_wide >> DivShift);
        if ((state_reg == ST_FETCH) && out_free)
        begin
            if (fetch_reg < limit)
            begin
                found_reg  <= 1'b1;
                cell_x_reg <= rd_entry.x;
                cell_z_reg <= rd_entry.z;
                last_reg   <= ((fetch_reg + KW'(1)) == limit);
            end
            else
            begin
                found_reg  <= 1'b0;
                cell_x_reg <= '0;
                cell_z_reg <= '0;
                last_reg   <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign cell_x    = cell_x_reg;
    assign cell_z    = cell_z_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== tb/terrain_cell_topk_checker.sv =====
`timescale 1ns / 1ps

module terrain_cell_topk_checker
    import tcs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    input  wire logic                in_valid,
    input  wire logic                in_stall,
    input  wire logic [1:0]          cmd,
    input  wire logic [15:0]         height,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire logic                found,
    input  wire logic [CoordW-1:0]   cell_x,
    input  wire logic [CoordW-1:0]   cell_z,
    input  wire logic                last,
    output int                       errors,
    output int                       pending,
    output int                       words_seen,
    output int                       cells_returned
);

    localparam int NumTrees = 220;
    localparam int LineLen  = 1024;

    typedef struct {
        logic             found;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] z;
        logic             last;
    } fetch_word_t;

    fetch_word_t fetch_queue[$];

    logic [15:0] line_up[LineLen];
    logic [15:0] line_mid[LineLen];
    logic [23:0] kept_score[NumTrees];
    logic [9:0]  kept_x[NumTrees];
    logic [9:0]  kept_z[NumTrees];
    int          col_n, row_n, kept_n, next_fetch;
    logic [15:0] w_c2, w_c1, w_a1, w_b1;

    logic [10:0] r_width, r_depth;
    logic [31:0] r_seed;
    logic [15:0] r_floor, r_slope;
    logic        r_on;

    function automatic int clamp_size(logic [10:0] v);
        int s;
        s = int'(v);
        if (s < 3) s = 3;
        if (s > 1024) s = 1024;
        return s;
    endfunction

    function automatic logic [23:0] cell_score(int x, int z);
        logic [31:0] h;
        logic [31:0] xs, zs, salt;
        xs = 32'(x);
        zs = 32'(z);
        salt = 32'd10 * 32'hc2b2ae3d;
        h = r_seed ^ (xs * 32'h9e3779b1) ^ (zs * 32'h85ebca77) ^ salt;
        h = h ^ (h >> 16);
        h = h * 32'h7feb352d;
        h = h ^ (h >> 15);
        h = h * 32'h846ca68b;
        h = h ^ (h >> 16);
        return h[23:0];
    endfunction

    function automatic bit near(logic [15:0] n, int c);
        int d;
        d = int'($signed(n)) - c;
        if (d < 0) d = -d;
        return d <= int'(r_slope);
    endfunction

    task automatic insert_cell(logic [23:0] s, int x, int z);
        int pos, top, i;
        pos = kept_n;
        while (pos > 0 && kept_score[pos-1] > s) pos--;
        if (pos >= NumTrees) return;
        top = (kept_n < NumTrees) ? kept_n : NumTrees - 1;
        for (i = top; i > pos; i--)
        begin
            kept_score[i] = kept_score[i-1];
            kept_x[i] = kept_x[i-1];
            kept_z[i] = kept_z[i-1];
        end
        kept_score[pos] = s;
        kept_x[pos] = 10'(x);
        kept_z[pos] = 10'(z);
        if (kept_n < NumTrees) kept_n++;
    endtask

    task automatic add_sample(logic [15:0] hv);
        int w, x, z, c;
        logic [15:0] old_c, old_a;
        logic [23:0] s;
        w = clamp_size(r_width);
        if (col_n >= w)
        begin
            col_n = 0;
            row_n++;
        end
        if (row_n >= clamp_size(r_depth)) return;
        x = col_n;
        z = row_n;
        old_c = line_mid[x];
        old_a = line_up[x];
        line_up[x] = old_c;
        line_mid[x] = hv;
        if (x >= 2 && z >= 2 && r_on)
        begin
            c = int'($signed(w_c1));
            if (c > int'($signed(r_floor)) && near(old_c, c) && near(w_c2, c)
                && near(w_a1, c) && near(w_b1, c))
            begin
                s = cell_score(x - 1, z - 1);
                if (s <= 24'd7046430) insert_cell(s, x - 1, z - 1);
            end
        end
        w_c2 = w_c1;
        w_c1 = old_c;
        w_a1 = old_a;
        w_b1 = hv;
        col_n++;
        if (col_n >= w)
        begin
            col_n = 0;
            row_n++;
        end
    endtask

    task automatic predict_fetch();
        fetch_word_t e;
        int want, lim;
        want = (clamp_size(r_width) * clamp_size(r_depth)) / 55;
        if (want < 8) want = 8;
        if (want > NumTrees) want = NumTrees;
        lim = (kept_n < want) ? kept_n : want;
        if (next_fetch < lim)
        begin
            e.found = 1'b1;
            e.x = kept_x[next_fetch];
            e.z = kept_z[next_fetch];
            e.last = (next_fetch + 1 == lim);
            next_fetch++;
        end
        else
        begin
            e.found = 1'b0;
            e.x = '0;
            e.z = '0;
            e.last = 1'b0;
        end
        fetch_queue = {fetch_queue, e};
    endtask

    task automatic compare_word();
        fetch_word_t e;
        words_seen++;
        if (found) cells_returned++;
        if (fetch_queue.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected word found=%0d x=%0d z=%0d last=%0d",
                     $time, found, cell_x, cell_z, last);
            return;
        end
        e = fetch_queue.pop_front();
        if (found !== e.found)
        begin
            errors++;
            $display("%0t: found expected %0d actual %0d", $time, e.found, found);
        end
        if (cell_x !== e.x)
        begin
            errors++;
            $display("%0t: cell_x expected %0d actual %0d", $time, e.x, cell_x);
        end
        if (cell_z !== e.z)
        begin
            errors++;
            $display("%0t: cell_z expected %0d actual %0d", $time, e.z, cell_z);
        end
        if (last !== e.last)
        begin
            errors++;
            $display("%0t: last expected %0d actual %0d", $time, e.last, last);
        end
    endtask

    initial
    begin
        errors = 0;
        words_seen = 0;
        cells_returned = 0;
        pending = 0;
        for (int i = 0; i < LineLen; i++)
        begin
            line_up[i] = '0;
            line_mid[i] = '0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_n = 0;
            row_n = 0;
            kept_n = 0;
            next_fetch = 0;
            w_c2 = '0;
            w_c1 = '0;
            w_a1 = '0;
            w_b1 = '0;
            r_width = 11'd64;
            r_depth = 11'd64;
            r_seed = '0;
            r_floor = 16'd46;
            r_slope = 16'd294;
            r_on = 1'b1;
            fetch_queue.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall) compare_word();
            if (cfg_write)
            begin
                case (cfg_index)
                    CfgMapWidth:    r_width = cfg_data[10:0];
                    CfgMapDepth:    r_depth = cfg_data[10:0];
                    CfgHashSeed:    r_seed = cfg_data;
                    CfgGroundFloor: r_floor = cfg_data[15:0];
                    CfgSlopeLimit:  r_slope = cfg_data[15:0];
                    CfgPlacementOn: r_on = cfg_data[0];
                    default:        ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                case (cmd)
                    CmdSample: add_sample(height);
                    CmdFetch:  predict_fetch();
                    CmdNewMap:
                    begin
                        col_n = 0;
                        row_n = 0;
                        kept_n = 0;
                        next_fetch = 0;
                    end
                    default:   ;
                endcase
            end
            pending = fetch_queue.size();
        end
    end

endmodule

// ===== tb/tb_terrain_cell_topk_selector.sv =====
`timescale 1ns / 1ps

module tb_terrain_cell_topk_selector;
    import tcs_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          cmd;
    logic [15:0]         height;
    logic                out_valid;
    logic                out_stall;
    logic                found;
    logic [CoordW-1:0]   cell_x;
    logic [CoordW-1:0]   cell_z;
    logic                last;

    int errors, pending, words_seen, cells_returned;
    int idle_cycles, burst_left, stall_mode, stall_left;
    int samples_sent, maps_run;
    int base_height, height_mode;

    localparam logic [1:0] CmdUnused = 2'd3;
    localparam int IdleLimit = 5000;

    terrain_cell_topk_selector uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .height(height),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .cell_x(cell_x), .cell_z(cell_z), .last(last)
    );

    terrain_cell_topk_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .height(height),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .cell_x(cell_x), .cell_z(cell_z), .last(last),
        .errors(errors), .pending(pending), .words_seen(words_seen),
        .cells_returned(cells_returned)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ($urandom_range(0, 99) < 75);
            default: out_stall <= (stall_left % 4) == 0;
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IdleLimit)
        begin
            $display("Watchdog expired at %0t", $time);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] c, logic [15:0] h);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 15);
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= c;
        height <= h;
        do
            @(posedge clk);
        while (in_stall);
        if (c == CmdSample) samples_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(int w, int d, logic [31:0] seed, int fl, int sl, bit on);
        drain();
        write_reg(CfgMapWidth, 32'(w));
        write_reg(CfgMapDepth, 32'(d));
        write_reg(CfgHashSeed, seed);
        write_reg(CfgGroundFloor, 32'(fl) & 32'hffff);
        write_reg(CfgSlopeLimit, 32'(sl));
        write_reg(CfgPlacementOn, 32'(on));
        @(negedge clk);
    endtask

    function automatic logic [15:0] next_height();
        int v;
        case (height_mode)
            0: v = $urandom_range(0, 65535);
            1: v = base_height + $urandom_range(0, 200) - 100;
            default: v = base_height;
        endcase
        if (height_mode != 0)
        begin
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
        end
        return 16'(v);
    endfunction

    function automatic int eff(int v);
        if (v < 3) return 3;
        if (v > 1024) return 1024;
        return v;
    endfunction

    task automatic run_map(int wr, int dr, bit noisy);
        int cells, want;
        cells = eff(wr) * eff(dr);
        want = cells / 55;
        if (want < 8) want = 8;
        if (want > 220) want = 220;
        maps_run++;
        send_word(CmdNewMap, 16'($urandom));
        for (int i = 0; i < cells; i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_word($urandom_range(0, 1) ? CmdFetch : CmdUnused, 16'($urandom));
            send_word(CmdSample, next_height());
        end
        if (noisy && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) send_word(CmdSample, next_height());
        repeat (want + 2) send_word(CmdFetch, 16'($urandom));
    endtask

    task automatic run_partial(int samples, int fetches);
        maps_run++;
        send_word(CmdNewMap, 16'($urandom));
        repeat (samples) send_word(CmdSample, next_height());
        repeat (fetches) send_word(CmdFetch, 16'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = CmdSample;
        height = '0;
        out_stall = 1'b0;
        idle_cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        samples_sent = 0;
        maps_run = 0;
        base_height = 0;
        height_mode = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_word(CmdFetch, 16'h0000);
        send_word(CmdUnused, 16'hffff);
        send_word(CmdNewMap, 16'h0000);
        send_word(CmdFetch, 16'h0000);

        configure(3, 3, 32'hffffffff, -32768, 65535, 1'b1);
        height_mode = 0;
        send_word(CmdNewMap, 16'h0000);
        send_word(CmdSample, 16'h7fff);
        send_word(CmdSample, 16'h8000);
        send_word(CmdSample, 16'h7fff);
        send_word(CmdSample, 16'h8000);
        send_word(CmdSample, 16'h7fff);
        send_word(CmdSample, 16'h8000);
        send_word(CmdSample, 16'h7fff);
        send_word(CmdSample, 16'h8000);
        send_word(CmdSample, 16'h7fff);
        send_word(CmdSample, 16'h0000);
        repeat (3) send_word(CmdFetch, 16'h0000);

        configure(4, 4, 32'h0, 32767, 0, 1'b1);
        height_mode = 2;
        base_height = 32767;
        run_map(4, 4, 0);
        configure(4, 4, 32'h12345678, -32768, 0, 1'b1);
        run_map(4, 4, 0);

        for (int m = 0; m < 7; m++)
        begin
            int w, d, fl, sl;
            w = $urandom_range(2, 8);
            d = $urandom_range(2, 8);
            if (m == 3) w = 0;
            if (m == 5) d = 1;
            height_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
            base_height = int'($urandom_range(0, 8000)) - 4000;
            fl = base_height - int'($urandom_range(0, 300));
            sl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(60, 250);
            configure(w, d, $urandom, fl, sl, $urandom_range(0, 7) != 0);
            run_map(w, d, 1);
        end

        height_mode = 0;
        configure(2047, 3, $urandom, -32768, 65535, 1'b1);
        run_partial(30, 4);
        configure(0, 2047, $urandom, -32768, 65535, 1'b1);
        run_partial(40, 8);

        drain();
        $display("Covered %0d maps, %0d height samples, %0d fetch words (%0d cells).",
                 maps_run, samples_sent, words_seen, cells_returned);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
